[design/gray_scott_residual_stencil_defines.svh]
// Assertion macros used by the residual stencil top level.
`ifndef GRAY_SCOTT_RESIDUAL_STENCIL_DEFINES_SVH
`define GRAY_SCOTT_RESIDUAL_STENCIL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GSRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsrs check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define GSRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsrs check failed");

`endif

[design/gsrs_pkg.sv]
// Constants, types and helper functions of the residual stencil.
package gsrs_pkg;

  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int DATA_W     = 32;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int DIM_W      = ROW_W + 1;
  localparam int DIMC_W     = COL_W + 1;
  localparam int ADDR_W     = $clog2(MAX_ROWS * MAX_COLS);
  localparam int GRID_W     = 8;
  localparam int COEF_W     = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int FRAC   = 24;
  localparam int LAP_W  = DATA_W + 6;
  localparam int OPA_W  = DATA_W + 8;
  localparam int OPB_W  = DATA_W + 1;
  localparam int PROD_W = 2 * OPB_W;
  localparam int TERM_W = DATA_W + 18;
  localparam int ACC_W  = TERM_W + 2;

  localparam int N_TAPS  = 9;
  localparam int N_STEPS = 12;
  localparam int TAP_W   = $clog2(N_TAPS + 1);
  localparam int STEP_W  = $clog2(N_STEPS);

  localparam logic signed [OPA_W-1:0] Q_ONE = OPA_W'(1) << FRAC;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS      = 3'd0,
    REG_GRID_COLS      = 3'd1,
    REG_DIFF_U         = 3'd2,
    REG_DIFF_V         = 3'd3,
    REG_FEED_RATE      = 3'd4,
    REG_FEED_PLUS_KILL = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_VV    = 3'd0,
    OP_LAP_U = 3'd1,
    OP_FEED  = 3'd2,
    OP_KILL  = 3'd3,
    OP_LAP_V = 3'd4,
    OP_UVV   = 3'd5
  } op_t;

  function automatic logic [ADDR_W-1:0] gsrs_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
  endfunction

  function automatic logic signed [DATA_W-1:0] gsrs_sat(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    lo_lim = {{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (x > hi_lim) begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end else if (x < lo_lim) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end
    return DATA_W'(x);
  endfunction

endpackage

[design/gray_scott_residual_stencil.sv]
// Top level: Gray-Scott residual on a periodic grid with a shared multiplier.
//
//  channel  | handshake            | carries
//  ---------+----------------------+------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in       | in_valid/in_stall    | action, row, col, u_value, v_value, u_rate, v_rate
//  out      | out_valid/out_stall  | residual_u, residual_v, bad_index
//
// Load: written into both stores at the accept edge, no result.
// Out-of-grid item: goes to ST_FINISH; its result is registered with bad_index set.
// Evaluate: nine single-port store reads, twelve passes of one 33x33 multiplier,
//   drain and output.
// in_stall is high while an item is in work; a pending result waits in the
//   output register. rst is synchronous, resets control and sets configuration to defaults.
`include "gray_scott_residual_stencil_defines.svh"

module gray_scott_residual_stencil (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gsrs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gsrs_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   action,
  input  logic [gsrs_pkg::ROW_W-1:0]             row,
  input  logic [gsrs_pkg::COL_W-1:0]             col,
  input  logic signed [gsrs_pkg::DATA_W-1:0]     u_value,
  input  logic signed [gsrs_pkg::DATA_W-1:0]     v_value,
  input  logic signed [gsrs_pkg::DATA_W-1:0]     u_rate,
  input  logic signed [gsrs_pkg::DATA_W-1:0]     v_rate,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [gsrs_pkg::DATA_W-1:0]     residual_u,
  output logic signed [gsrs_pkg::DATA_W-1:0]     residual_v,
  output logic                                   bad_index
);
  import gsrs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;

  logic [GRID_W-1:0] grid_rows, grid_cols;
  logic [COEF_W-1:0] diff_u, diff_v, feed, fpk;

  logic [ROW_W-1:0] r_q, rm, rp;
  logic [COL_W-1:0] c_q, cm, cp;
  logic             bad_q;
  logic [TAP_W-1:0]  tap;
  logic [STEP_W-1:0] step;

  logic signed [LAP_W-1:0]  lap_u, lap_v;
  logic signed [DATA_W-1:0] u_c, v_c;
  logic signed [OPA_W-1:0]  vv;
  logic signed [ACC_W-1:0]  acc_u, acc_v;
  logic signed [PROD_W-1:0] prod;
  logic                     p_vld, p_hi;
  op_t                      p_op;
  logic signed [TERM_W-1:0] term;

  logic [DIM_W-1:0]  rows_eff;
  logic [DIMC_W-1:0] cols_eff;
  logic              in_bad, accept, load_we;
  logic [ADDR_W-1:0] in_addr, tap_addr, uv_addr, rate_addr;
  logic [ROW_W-1:0]  tap_r;
  logic [COL_W-1:0]  tap_c;
  logic [2*DATA_W-1:0] uv_rd, rate_rd;
  logic signed [DATA_W-1:0] u_rd, v_rd, ur_rd, vr_rd;
  logic signed [LAP_W-1:0]  xu, xv, wu, wv;
  logic [TAP_W-1:0]  rd_tap;

  op_t                      iss_op;
  logic                     iss_hi;
  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb, a_part;
  logic signed [TERM_W-1:0] fin;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_W'(99);
      grid_cols <= GRID_W'(99);
      diff_u    <= COEF_W'(350150);
      diff_v    <= COEF_W'(175075);
      feed      <= COEF_W'(402653);
      fpk       <= COEF_W'(1409286);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_ROWS:      grid_rows <= cfg_data[GRID_W-1:0];
        REG_GRID_COLS:      grid_cols <= cfg_data[GRID_W-1:0];
        REG_DIFF_U:         diff_u    <= cfg_data[COEF_W-1:0];
        REG_DIFF_V:         diff_v    <= cfg_data[COEF_W-1:0];
        REG_FEED_RATE:      feed      <= cfg_data[COEF_W-1:0];
        REG_FEED_PLUS_KILL: fpk       <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rows_eff = (32'(grid_rows) > 32'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(grid_rows);
    cols_eff = (32'(grid_cols) > 32'(MAX_COLS)) ? DIMC_W'(MAX_COLS) : DIMC_W'(grid_cols);
    in_bad   = (DIM_W'(row) >= rows_eff) || (DIMC_W'(col) >= cols_eff);
    in_addr  = gsrs_addr(row, col);
    in_stall = (state != ST_IDLE);
    accept   = in_valid && !in_stall;
    load_we  = accept && !action && !in_bad;
  end

  always_comb begin
    case (tap)
      TAP_W'(1): begin tap_r = rm;  tap_c = cm;  end
      TAP_W'(2): begin tap_r = rm;  tap_c = cp;  end
      TAP_W'(3): begin tap_r = rp;  tap_c = cm;  end
      TAP_W'(4): begin tap_r = rp;  tap_c = cp;  end
      TAP_W'(5): begin tap_r = rm;  tap_c = c_q; end
      TAP_W'(6): begin tap_r = rp;  tap_c = c_q; end
      TAP_W'(7): begin tap_r = r_q; tap_c = cm;  end
      TAP_W'(8): begin tap_r = r_q; tap_c = cp;  end
      default:   begin tap_r = r_q; tap_c = c_q; end
    endcase
    tap_addr  = gsrs_addr(tap_r, tap_c);
    uv_addr   = (state == ST_IDLE) ? in_addr : tap_addr;
    rate_addr = (state == ST_IDLE) ? in_addr : gsrs_addr(r_q, c_q);
  end

  gsrs_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_uv_ram (
    .clk   (clk),
    .we    (load_we),
    .addr  (uv_addr),
    .wdata ({u_value, v_value}),
    .rdata (uv_rd)
  );

  gsrs_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_ROWS * MAX_COLS)) u_rate_ram (
    .clk   (clk),
    .we    (load_we),
    .addr  (rate_addr),
    .wdata ({u_rate, v_rate}),
    .rdata (rate_rd)
  );

  always_comb begin
    u_rd   = uv_rd[2*DATA_W-1:DATA_W];
    v_rd   = uv_rd[DATA_W-1:0];
    ur_rd  = rate_rd[2*DATA_W-1:DATA_W];
    vr_rd  = rate_rd[DATA_W-1:0];
    xu     = LAP_W'(u_rd);
    xv     = LAP_W'(v_rd);
    rd_tap = tap - TAP_W'(1);
    case (rd_tap)
      TAP_W'(0): begin
        wu = -((xu <<< 4) + (xu <<< 2));
        wv = -((xv <<< 4) + (xv <<< 2));
      end
      TAP_W'(1), TAP_W'(2), TAP_W'(3), TAP_W'(4): begin
        wu = xu;
        wv = xv;
      end
      default: begin
        wu = xu <<< 2;
        wv = xv <<< 2;
      end
    endcase
  end

  always_comb begin
    iss_op = op_t'(step[STEP_W-1:1]);
    iss_hi = step[0];
    case (iss_op)
      OP_VV:    begin opa = OPA_W'(v_c);          opb = OPB_W'(v_c);            end
      OP_LAP_U: begin opa = OPA_W'(lap_u);        opb = signed'({2'b00, diff_u}); end
      OP_FEED:  begin opa = Q_ONE - OPA_W'(u_c);  opb = signed'({2'b00, feed});   end
      OP_KILL:  begin opa = OPA_W'(v_c);          opb = signed'({2'b00, fpk});    end
      OP_LAP_V: begin opa = OPA_W'(lap_v);        opb = signed'({2'b00, diff_v}); end
      OP_UVV:   begin opa = vv;                   opb = OPB_W'(u_c);            end
      default:  begin opa = '0;                   opb = '0;                     end
    endcase
    a_part = iss_hi ? OPB_W'(opa >>> FRAC)
                    : signed'({{(OPB_W-FRAC){1'b0}}, opa[FRAC-1:0]});
    fin    = term + TERM_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      p_vld     <= 1'b0;
    end else begin
      p_vld <= (state == ST_MUL);
      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      if (p_vld) begin
        if (!p_hi) begin
          term <= TERM_W'(prod >>> FRAC);
        end else begin
          case (p_op)
            OP_VV:    vv <= OPA_W'(fin);
            OP_LAP_U: acc_u <= acc_u - ACC_W'(fin);
            OP_FEED:  acc_u <= acc_u - ACC_W'(fin);
            OP_KILL:  acc_v <= acc_v + ACC_W'(fin);
            OP_LAP_V: acc_v <= acc_v - ACC_W'(fin);
            OP_UVV: begin
              acc_u <= acc_u + ACC_W'(fin);
              acc_v <= acc_v - ACC_W'(fin);
            end
            default: ;
          endcase
        end
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            r_q   <= row;
            c_q   <= col;
            rm    <= (row == '0) ? ROW_W'(rows_eff - DIM_W'(1)) : row - ROW_W'(1);
            rp    <= (DIM_W'(row) + DIM_W'(1) == rows_eff) ? '0 : row + ROW_W'(1);
            cm    <= (col == '0) ? COL_W'(cols_eff - DIMC_W'(1)) : col - COL_W'(1);
            cp    <= (DIMC_W'(col) + DIMC_W'(1) == cols_eff) ? '0 : col + COL_W'(1);
            lap_u <= '0;
            lap_v <= '0;
            tap   <= '0;
            bad_q <= in_bad;
            if (in_bad) begin
              state <= ST_FINISH;
            end else if (action) begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (tap != '0) begin
            lap_u <= lap_u + wu;
            lap_v <= lap_v + wv;
          end
          if (tap == TAP_W'(1)) begin
            u_c   <= u_rd;
            v_c   <= v_rd;
            acc_u <= ACC_W'(ur_rd);
            acc_v <= ACC_W'(vr_rd);
          end
          if (tap == TAP_W'(N_TAPS)) begin
            step  <= '0;
            state <= ST_MUL;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        ST_MUL: begin
          prod <= a_part * opb;
          p_op <= iss_op;
          p_hi <= iss_hi;
          if (step == STEP_W'(N_STEPS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            bad_index  <= bad_q;
            residual_u <= bad_q ? '0 : gsrs_sat(acc_u);
            residual_v <= bad_q ? '0 : gsrs_sat(acc_v);
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `GSRS_ASSERT_NXT(a_eval_enters_read, accept && action && !in_bad, state == ST_READ)
  `GSRS_ASSERT_IMP(a_prod_in_mul, p_vld, state == ST_MUL || state == ST_DRAIN)
  `GSRS_ASSERT_IMP(a_bad_is_zero, out_valid && bad_index, residual_u == '0 && residual_v == '0)
  `GSRS_ASSERT_NXT(a_finish_delivers, state == ST_FINISH && (!out_valid || !out_stall), out_valid && state == ST_IDLE)

endmodule

[design/gsrs_ram.sv]
// Generic single-port RAM with registered read.
module gsrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
